@@ rtl/ldt_pkg.sv @@
`default_nettype none

package ldt_pkg;

  localparam int SLOT_COUNT_DEFAULT = 128;

  // Service codes
  localparam logic [15:0] KIND_ALLOC    = 16'h0000;
  localparam logic [15:0] KIND_FREE     = 16'h0001;
  localparam logic [15:0] KIND_INCR     = 16'h0003;
  localparam logic [15:0] KIND_GETBASE  = 16'h0006;
  localparam logic [15:0] KIND_SETBASE  = 16'h0007;
  localparam logic [15:0] KIND_SETLIMIT = 16'h0008;
  localparam logic [15:0] KIND_RIGHTS   = 16'h0009;
  localparam logic [15:0] KIND_VERSION  = 16'h0400;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NO_RUN,
    ERR_BAD_SEL,
    ERR_UNIMPL
  } err_e;

  // Register write mask bits
  localparam logic [4:0] MASK_AX = 5'h01;
  localparam logic [4:0] MASK_BX = 5'h02;
  localparam logic [4:0] MASK_CL = 5'h04;
  localparam logic [4:0] MASK_CX = 5'h08;
  localparam logic [4:0] MASK_DX = 5'h10;

  localparam logic [15:0] AX_NO_RUN    = 16'h0008;
  localparam logic [15:0] AX_BAD_SEL   = 16'h8022;
  localparam logic [15:0] AX_UNIMPL    = 16'h8001;
  localparam logic [15:0] AX_INCREMENT = 16'h0008;
  localparam logic [15:0] AX_VERSION   = 16'h005A;
  localparam logic [15:0] BX_VERSION   = 16'h0001;
  localparam logic [7:0]  CL_VERSION   = 8'h03;
  localparam logic [15:0] DX_VERSION   = 16'hFFFF;

  localparam logic [31:0] LIMIT_BYTE_MAX = 32'h000F_FFFF;

  // Fresh slot: base 0, limit 0, access 0x92, flags 0x40
  localparam logic [63:0] ALLOC_DESC = 64'h0040_9200_0000_0000;

  typedef enum logic [3:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INCR,
    OP_GETBASE,
    OP_SETBASE,
    OP_SETLIMIT,
    OP_RIGHTS,
    OP_VERSION,
    OP_BAD_SEL,
    OP_UNIMPL
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FILL,
    ST_DESC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] kind;
    logic [15:0] selector;
    logic [15:0] arg_high;
    logic [15:0] arg_low;
  } req_t;

  typedef struct packed {
    logic        carry;
    logic [1:0]  error_kind;
    logic [4:0]  write_mask;
    logic [15:0] ax_word;
    logic [15:0] bx_word;
    logic [7:0]  cl_byte;
    logic [15:0] cx_word;
    logic [15:0] dx_word;
  } res_t;

  typedef struct packed {
    logic clear_step;
    logic req_load;
    logic alloc_init;
    logic scan_step;
    logic fill_step;
    logic free_write;
    logic desc_read;
    logic desc_write;
    logic result_load;
  } ldt_cmd_t;

  typedef struct packed {
    logic clear_last;
    op_e  op;
    logic count_zero;
    logic scan_hit;
    logic scan_exhausted;
    logic fill_last;
    logic out_free;
  } ldt_status_t;

  function automatic op_e decode_op(logic [15:0] kind, logic sel_ok);
    op_e op;
    case (kind)
      KIND_ALLOC:    op = OP_ALLOC;
      KIND_FREE:     op = sel_ok ? OP_FREE : OP_BAD_SEL;
      KIND_INCR:     op = OP_INCR;
      KIND_GETBASE:  op = sel_ok ? OP_GETBASE : OP_BAD_SEL;
      KIND_SETBASE:  op = sel_ok ? OP_SETBASE : OP_BAD_SEL;
      KIND_SETLIMIT: op = sel_ok ? OP_SETLIMIT : OP_BAD_SEL;
      KIND_RIGHTS:   op = sel_ok ? OP_RIGHTS : OP_BAD_SEL;
      KIND_VERSION:  op = OP_VERSION;
      default:       op = OP_UNIMPL;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ldt_ctrl.sv @@
`default_nettype none

module ldt_ctrl import ldt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire ldt_status_t status_i,
  output ldt_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (status_i.op)
          OP_ALLOC:    state_d = status_i.count_zero ? ST_DONE : ST_SCAN;
          OP_GETBASE,
          OP_SETBASE,
          OP_SETLIMIT,
          OP_RIGHTS:   state_d = ST_DESC;
          default:     state_d = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (status_i.scan_hit) begin
          state_d = ST_FILL;
        end else if (status_i.scan_exhausted) begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        if (status_i.fill_last) state_d = ST_DONE;
      end
      ST_DESC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.req_load = in_valid_i;
      end
      ST_DECODE: begin
        case (status_i.op)
          OP_ALLOC:    cmd_o.alloc_init = 1'b1;
          OP_FREE:     cmd_o.free_write = 1'b1;
          OP_GETBASE,
          OP_SETBASE,
          OP_SETLIMIT,
          OP_RIGHTS:   cmd_o.desc_read  = 1'b1;
          default:     ;
        endcase
      end
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_FILL: cmd_o.fill_step = 1'b1;
      ST_DESC: cmd_o.desc_write = (status_i.op != OP_GETBASE);
      ST_DONE: cmd_o.result_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ldt_datapath.sv @@
`default_nettype none

module ldt_datapath import ldt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire req_t     in_data_i,
  input  wire ldt_cmd_t cmd_i,
  output ldt_status_t   status_o,
  input  wire logic     out_ready_i,
  output logic          out_valid_o,
  output res_t          out_data_o
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] LAST_SLOT = CW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] SLOT_END  = CW'(SLOT_COUNT);

  logic        used_mem [SLOT_COUNT];
  logic [63:0] desc_mem [SLOT_COUNT];

  req_t          req_q;
  logic [AW-1:0] clr_addr_q;
  logic [CW-1:0] scan_addr_q;
  logic          chk_valid_q;
  logic [CW-1:0] chk_addr_q;
  logic [CW-1:0] run_start_q;
  logic [CW-1:0] run_len_q;
  logic          used_rd_q;
  logic [AW-1:0] fill_addr_q;
  logic [CW-1:0] fill_cnt_q;
  logic [CW-1:0] alloc_first_q;
  logic          scan_fail_q;
  logic [63:0]   desc_rd_q;
  logic          out_valid_q;
  res_t          out_q;

  logic [12:0]   sel_idx;
  logic          sel_ok;
  logic [AW-1:0] slot_addr;
  op_e           op;
  logic [CW-1:0] run_len_inc;
  logic          scan_issue;
  logic          scan_hit;
  logic          scan_exhausted;
  logic          out_free;
  logic [31:0]   limit_full;
  logic [19:0]   limit_val;
  logic [3:0]    flag_hi;
  logic [63:0]   desc_new;
  res_t          res_d;

  // Request decode
  assign sel_idx   = req_q.selector[15:3];
  assign sel_ok    = req_q.selector[2] && (sel_idx != 13'd0) &&
                     ({19'd0, sel_idx} < 32'(SLOT_COUNT));
  assign slot_addr = sel_idx[AW-1:0];
  assign op        = decode_op(req_q.kind, sel_ok);

  // First-fit scan: the used bit for chk_addr_q is registered in used_rd_q
  assign run_len_inc    = run_len_q + 1'b1;
  assign scan_issue     = cmd_i.scan_step && (scan_addr_q < SLOT_END);
  assign scan_hit       = chk_valid_q && !used_rd_q &&
                          (16'(run_len_inc) == req_q.arg_high);
  assign scan_exhausted = chk_valid_q && !scan_hit && (chk_addr_q == LAST_SLOT);
  assign out_free       = !out_valid_q || out_ready_i;

  always_comb begin
    status_o                = '0;
    status_o.clear_last     = (clr_addr_q == AW'(SLOT_COUNT - 1));
    status_o.op             = op;
    status_o.count_zero     = (req_q.arg_high == 16'd0);
    status_o.scan_hit       = scan_hit;
    status_o.scan_exhausted = scan_exhausted;
    status_o.fill_last      = (16'(fill_cnt_q) == (req_q.arg_high - 16'd1));
    status_o.out_free       = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) req_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q    <= '0;
      scan_addr_q   <= '0;
      chk_valid_q   <= 1'b0;
      chk_addr_q    <= '0;
      run_start_q   <= '0;
      run_len_q     <= '0;
      fill_addr_q   <= '0;
      fill_cnt_q    <= '0;
      alloc_first_q <= '0;
      scan_fail_q   <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.alloc_init) begin
        scan_addr_q   <= CW'(1);
        chk_valid_q   <= 1'b0;
        run_start_q   <= CW'(1);
        run_len_q     <= '0;
        fill_cnt_q    <= '0;
        alloc_first_q <= CW'(1);
        scan_fail_q   <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        chk_valid_q <= scan_issue;
        chk_addr_q  <= scan_addr_q;
        if (scan_issue) scan_addr_q <= scan_addr_q + 1'b1;
        if (chk_valid_q) begin
          if (used_rd_q) begin
            run_len_q   <= '0;
            run_start_q <= chk_addr_q + 1'b1;
          end else begin
            run_len_q <= run_len_inc;
          end
        end
        if (scan_hit) begin
          alloc_first_q <= run_start_q;
          fill_addr_q   <= run_start_q[AW-1:0];
        end
        if (scan_exhausted) scan_fail_q <= 1'b1;
      end
      if (cmd_i.fill_step) begin
        fill_addr_q <= fill_addr_q + 1'b1;
        fill_cnt_q  <= fill_cnt_q + 1'b1;
      end
    end
  end

  // Slot-used map
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      used_mem[clr_addr_q] <= 1'b0;
    end else if (cmd_i.free_write) begin
      used_mem[slot_addr] <= 1'b0;
    end else if (cmd_i.fill_step) begin
      used_mem[fill_addr_q] <= 1'b1;
    end
    if (scan_issue) used_rd_q <= used_mem[scan_addr_q[AW-1:0]];
  end

  // Descriptor table
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      desc_mem[clr_addr_q] <= '0;
    end else if (cmd_i.fill_step) begin
      desc_mem[fill_addr_q] <= ALLOC_DESC;
    end else if (cmd_i.desc_write) begin
      desc_mem[slot_addr] <= desc_new;
    end
    if (cmd_i.desc_read) desc_rd_q <= desc_mem[slot_addr];
  end

  // Read-modify-write of one descriptor
  always_comb begin
    limit_full = {req_q.arg_high, req_q.arg_low};
    limit_val  = limit_full[19:0];
    flag_hi    = desc_rd_q[55:52];
    desc_new   = desc_rd_q;
    if (limit_full > LIMIT_BYTE_MAX) begin
      limit_val  = limit_full[31:12];
      flag_hi[3] = 1'b1;
    end
    case (op)
      OP_SETBASE: begin
        desc_new[31:16] = req_q.arg_low;
        desc_new[39:32] = req_q.arg_high[7:0];
        desc_new[63:56] = req_q.arg_high[15:8];
      end
      OP_SETLIMIT: begin
        desc_new[15:0]  = limit_val[15:0];
        desc_new[55:48] = {flag_hi, limit_val[19:16]};
      end
      OP_RIGHTS: begin
        desc_new[47:40] = req_q.arg_high[7:0];
        desc_new[55:52] = req_q.arg_high[15:12];
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    res_d = '0;
    case (op)
      OP_ALLOC: begin
        res_d.write_mask = MASK_AX;
        if (scan_fail_q) begin
          res_d.carry      = 1'b1;
          res_d.error_kind = ERR_NO_RUN;
          res_d.ax_word    = AX_NO_RUN;
        end else begin
          res_d.ax_word = 16'({alloc_first_q, 3'b100});
        end
      end
      OP_INCR: begin
        res_d.write_mask = MASK_AX;
        res_d.ax_word    = AX_INCREMENT;
      end
      OP_GETBASE: begin
        res_d.write_mask = MASK_CX | MASK_DX;
        res_d.cx_word    = {desc_rd_q[63:56], desc_rd_q[39:32]};
        res_d.dx_word    = desc_rd_q[31:16];
      end
      OP_VERSION: begin
        res_d.write_mask = MASK_AX | MASK_BX | MASK_CL | MASK_DX;
        res_d.ax_word    = AX_VERSION;
        res_d.bx_word    = BX_VERSION;
        res_d.cl_byte    = CL_VERSION;
        res_d.dx_word    = DX_VERSION;
      end
      OP_BAD_SEL: begin
        res_d.carry      = 1'b1;
        res_d.error_kind = ERR_BAD_SEL;
        res_d.write_mask = MASK_AX;
        res_d.ax_word    = AX_BAD_SEL;
      end
      OP_UNIMPL: begin
        res_d.carry      = 1'b1;
        res_d.error_kind = ERR_UNIMPL;
        res_d.write_mask = MASK_AX;
        res_d.ax_word    = AX_UNIMPL;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/ldt_descriptor_service.sv @@
// Descriptor table service block.
// Request channel (in_valid_i / in_ready_o / in_data_i): one word per service
// call carrying kind, selector, arg_high and arg_low. Response channel
// (out_valid_o / out_ready_i / out_data_o): exactly one word per request with
// carry, error kind, register write mask and the AX/BX/CL/CX/DX values.
// One request is in flight at a time; in_ready_o is high only while idle.
// Steps from request accept to response valid:
//   increment, version, free, bad selector, unknown code: decode, response
//   getbase, setbase, setlimit, rights: one table read, then one write
//   (none for getbase); alloc: the first-fit search reads one slot-used
//   bit per cycle through the map's single read port, then the run is
//   written one slot per cycle.
// The next request is taken the cycle after the response is loaded.
// After reset a clearing pass writes zero to every slot of the map and the
// table, one slot per cycle; no request is taken then.
// A stalled receiver holds the response in the output register; a new request
// is still accepted and processed, and its response waits until the register
// frees.
`default_nettype none

module ldt_descriptor_service import ldt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  ldt_cmd_t    cmd;
  ldt_status_t status;

  // Sequencer: clear pass, decode, scan, fill, table access, response
  ldt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Slot map, descriptor table, scan counters and response register
  ldt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/ldt_checker.sv @@
`default_nettype none

module ldt_checker import ldt_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire res_t out_data_o
);

  // Hold a stalled response word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response changed");

  // One request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  a_carry_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.carry == (out_data_o.error_kind != ERR_NONE)))
    else $error("carry and error kind disagree");

  a_fail_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.carry |-> out_data_o.write_mask == MASK_AX)
    else $error("failed request writes more than AX");

  a_unwritten_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.write_mask[0] || out_data_o.ax_word == 16'd0) &&
      (out_data_o.write_mask[1] || out_data_o.bx_word == 16'd0) &&
      (out_data_o.write_mask[2] || out_data_o.cl_byte == 8'd0) &&
      (out_data_o.write_mask[3] || out_data_o.cx_word == 16'd0) &&
      (out_data_o.write_mask[4] || out_data_o.dx_word == 16'd0))
    else $error("unwritten register field not zero");

endmodule

bind ldt_descriptor_service ldt_checker u_ldt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
